>>> hw/rtl/msf_pkg.sv
// ----------------------------------------------------------------------------
// msf_pkg
// Shared types and constants of the multichannel sensor smoothing filter.
// ----------------------------------------------------------------------------
package msf_pkg;

  // Sizing
  localparam int NUM_CHANNELS = 16;
  localparam int MAX_WINDOW   = 32;
  localparam int SAMPLE_BITS  = 16;

  localparam int CH_W     = 4;                     // channel index
  localparam int SLOT_W   = 5;                     // ring slot within a window
  localparam int CNT_W    = 6;                     // held count, 0..MAX_WINDOW
  localparam int SUM_W    = 22;                    // running sum of a window
  localparam int SMOOTH_W = 32;                    // Q16.16 estimate
  localparam int WEIGHT_W = 17;                    // Q1.16 weight, 0..1.0
  localparam int HIST_AW  = CH_W + SLOT_W;         // history address
  localparam int STEP_W   = $clog2(SUM_W + 1);     // divider step counter

  // Q1.16 constants
  localparam logic [WEIGHT_W-1:0] ONE_Q16  = 17'h10000;
  localparam logic [WEIGHT_W-1:0] HALF_Q16 = 17'h08000;

  // Register indexes
  localparam logic [1:0] CFG_FILTER_MODE      = 2'd0;
  localparam logic [1:0] CFG_WINDOW_LENGTH    = 2'd1;
  localparam logic [1:0] CFG_SMOOTHING_WEIGHT = 2'd2;

  // Field codes
  localparam logic MODE_MOVING_AVG = 1'b0;
  localparam logic MODE_EXP_SMOOTH = 1'b1;
  localparam logic KIND_SAMPLE     = 1'b0;
  localparam logic KIND_CLEAR_ALL  = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_DIV_WAIT,
    ST_MUL_NEW,
    ST_MUL_OLD,
    ST_ACC,
    ST_EXP,
    ST_OUT
  } msf_state_e;

  // Divider request and status
  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [CNT_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> hw/rtl/multichannel_sensor_smoothing_filter.sv
// ----------------------------------------------------------------------------
// multichannel_sensor_smoothing_filter
// Per-channel moving average or exponential smoothing of tagged samples.
// ----------------------------------------------------------------------------
//   port group | dir | tdata (low bit up)                  | tuser
//   s_axis     | in  | channel[3:0], sample_value[19:4]    | kind[0], connected[1]
//   m_axis     | out | out_channel[3:0], filtered_value    | passed_through[0]
//   cfg        | in  | index 0 mode, 1 window, 2 weight    | -
//
// Moving average: read, sum, a wait on the 22-step serial divider, then output.
// Exponential smoothing: one shared multiplier used twice, accumulate, round and
// output; a first sample after a clear goes from the first multiply to output, a
// disconnected sample straight to output. A clear-all item is taken in idle. Reset
// clears every channel at once. The input is ready only in idle; a result waiting
// at the output register does not block the next item, only the one after it.
// ----------------------------------------------------------------------------
module multichannel_sensor_smoothing_filter import msf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input items
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,   // channel[3:0], sample_value[19:4]
  input  logic [1:0]          s_axis_tuser,   // kind[0], connected[1]
  // result items
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata,   // out_channel[3:0], filtered_value[19:4]
  output logic [0:0]          m_axis_tuser,   // passed_through[0]
  // configuration
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [WEIGHT_W-1:0] cfg_data_i
);

  localparam int MUL_W = 18 + SMOOTH_W;
  localparam logic signed [MUL_W-1:0] ACC_HALF = MUL_W'(HALF_Q16);

  // Configuration
  logic                mode_q;
  logic [CNT_W-1:0]    window_q;
  logic [WEIGHT_W-1:0] weight_q;

  // Per-channel state
  logic [CNT_W-1:0]           count_q  [NUM_CHANNELS];
  logic [SLOT_W-1:0]          slot_q   [NUM_CHANNELS];
  logic                       seeded_q [NUM_CHANNELS];
  logic signed [SUM_W-1:0]    sum_q    [NUM_CHANNELS];
  logic signed [SMOOTH_W-1:0] smooth_q [NUM_CHANNELS];
  logic [SAMPLE_BITS-1:0]     hist_mem [2**HIST_AW];
  logic [SAMPLE_BITS-1:0]     hist_rd_q;

  // Sequencer and datapath
  msf_state_e                    state_q, state_d;
  logic [CH_W-1:0]               ch_q, ch_d;
  logic signed [SAMPLE_BITS-1:0] x_q, x_d;
  logic signed [SAMPLE_BITS-1:0] res_q, res_d;
  logic                          pass_q, pass_d;
  logic signed [MUL_W-1:0]       prod_q, prod_d;
  logic signed [MUL_W-1:0]       acc_q, acc_d;

  // Output register
  logic                          m_valid_q, m_valid_d;
  logic [CH_W-1:0]               out_ch_q;
  logic signed [SAMPLE_BITS-1:0] out_val_q;
  logic                          out_pass_q;
  logic                          out_load;

  // Input fields
  logic                          in_kind, in_conn, in_accept;
  logic [CH_W-1:0]               in_ch;
  logic signed [SAMPLE_BITS-1:0] in_x;

  assign in_kind   = s_axis_tuser[0];
  assign in_conn   = s_axis_tuser[1];
  assign in_ch     = s_axis_tdata[3:0];
  assign in_x      = s_axis_tdata[19:4];
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // Effective window and weight
  logic [CNT_W-1:0]    win_eff;
  logic [WEIGHT_W-1:0] weight_eff, weight_rest;

  assign win_eff = (window_q == '0) ? CNT_W'(1) :
                   (window_q > CNT_W'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW) : window_q;
  assign weight_eff  = (weight_q > ONE_Q16) ? ONE_Q16 : weight_q;
  assign weight_rest = ONE_Q16 - weight_eff;

  // Current channel view
  logic [CNT_W-1:0]           cur_count;
  logic [SLOT_W-1:0]          cur_slot;
  logic                       cur_seeded;
  logic signed [SUM_W-1:0]    cur_sum;
  logic signed [SMOOTH_W-1:0] cur_smooth;

  assign cur_count  = count_q[ch_q];
  assign cur_slot   = slot_q[ch_q];
  assign cur_seeded = seeded_q[ch_q];
  assign cur_sum    = sum_q[ch_q];
  assign cur_smooth = smooth_q[ch_q];

  // Window update
  logic                    full;
  logic signed [SUM_W-1:0] x_ext, hist_ext, sum_base, new_sum;
  logic [CNT_W-1:0]        new_count, slot_inc;
  logic [SLOT_W-1:0]       new_slot;
  logic [HIST_AW-1:0]      rd_addr, wr_addr;

  assign full      = cur_count >= win_eff;
  assign x_ext     = {{(SUM_W-SAMPLE_BITS){x_q[SAMPLE_BITS-1]}}, x_q};
  assign hist_ext  = {{(SUM_W-SAMPLE_BITS){hist_rd_q[SAMPLE_BITS-1]}}, hist_rd_q};
  assign sum_base  = (cur_count == '0) ? '0 : cur_sum;
  assign new_sum   = full ? (cur_sum - hist_ext + x_ext) : (sum_base + x_ext);
  assign new_count = full ? win_eff : (cur_count + 1'b1);
  assign slot_inc  = {1'b0, cur_slot} + 1'b1;
  assign new_slot  = !full ? cur_slot :
                     (slot_inc == win_eff) ? '0 : slot_inc[SLOT_W-1:0];
  assign rd_addr   = {ch_q, cur_slot};
  assign wr_addr   = {ch_q, full ? cur_slot : cur_count[SLOT_W-1:0]};

  // Divider
  div_req_t                div_req;
  div_status_t             div_st;
  logic signed [SUM_W-1:0] div_quo;

  assign div_req.start    = (state_q == ST_SUM);
  assign div_req.dividend = new_sum;
  assign div_req.divisor  = new_count;

  msf_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .status_o   (div_st),
    .quotient_o (div_quo)
  );

  // Shared multiplier: weight times new sample, then rest weight times estimate
  logic signed [17:0]          mul_a;
  logic signed [SMOOTH_W-1:0]  mul_b;
  logic signed [MUL_W-1:0]     mul_out;
  logic signed [SMOOTH_W-1:0]  s_new, s_seed;
  logic signed [SMOOTH_W:0]    s_round;

  assign mul_a   = (state_q == ST_MUL_NEW) ? $signed({1'b0, weight_eff})
                                           : $signed({1'b0, weight_rest});
  assign mul_b   = (state_q == ST_MUL_NEW) ?
                   $signed({{(SMOOTH_W-SAMPLE_BITS){x_q[SAMPLE_BITS-1]}}, x_q}) : cur_smooth;
  assign mul_out = mul_a * mul_b;
  assign s_new   = acc_q[16 +: SMOOTH_W];
  assign s_seed  = {x_q, 16'h0000};
  assign s_round = {s_new[SMOOTH_W-1], s_new} + $signed({{(SMOOTH_W+1-WEIGHT_W){1'b0}}, HALF_Q16});

  // Clear requests
  logic clear_all, clear_chan;

  assign clear_all  = (cfg_we_i && (cfg_index_i == CFG_FILTER_MODE ||
                                    cfg_index_i == CFG_WINDOW_LENGTH)) ||
                      (in_accept && in_kind == KIND_CLEAR_ALL);
  assign clear_chan = in_accept && in_kind == KIND_SAMPLE && !in_conn;

  // Next state and datapath
  always_comb begin
    state_d   = state_q;
    ch_d      = ch_q;
    x_d       = x_q;
    res_d     = res_q;
    pass_d    = pass_q;
    prod_d    = prod_q;
    acc_d     = acc_q;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && in_kind == KIND_SAMPLE) begin
          ch_d   = in_ch;
          x_d    = in_x;
          pass_d = 1'b0;
          if (!in_conn) begin
            res_d   = in_x;
            pass_d  = 1'b1;
            state_d = ST_OUT;
          end else if (mode_q == MODE_MOVING_AVG) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_MUL_NEW;
          end
        end
      end
      ST_READ: begin
        state_d = ST_SUM;
      end
      ST_SUM: begin
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_st.done) begin
          res_d   = div_quo[SAMPLE_BITS-1:0];
          state_d = ST_OUT;
        end
      end
      ST_MUL_NEW: begin
        if (!cur_seeded) begin
          res_d   = x_q;
          state_d = ST_OUT;
        end else begin
          prod_d  = mul_out;
          state_d = ST_MUL_OLD;
        end
      end
      ST_MUL_OLD: begin
        prod_d  = mul_out;
        acc_d   = (prod_q <<< 16) + ACC_HALF;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        acc_d   = acc_q + prod_q;
        state_d = ST_EXP;
      end
      ST_EXP: begin
        res_d   = s_round[16 +: SAMPLE_BITS];
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign m_valid_d = out_load || (m_valid_q && !m_axis_tready);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      mode_q    <= MODE_MOVING_AVG;
      window_q  <= CNT_W'(8);
      weight_q  <= HALF_Q16;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_FILTER_MODE:      mode_q   <= cfg_data_i[0];
          CFG_WINDOW_LENGTH:    window_q <= cfg_data_i[CNT_W-1:0];
          CFG_SMOOTHING_WEIGHT: weight_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    x_q    <= x_d;
    res_q  <= res_d;
    pass_q <= pass_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (out_load) begin
      out_ch_q   <= ch_q;
      out_val_q  <= res_q;
      out_pass_q <= pass_q;
    end
  end

  // Per-channel fill state: clear all, clear one, or advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        count_q[c]  <= '0;
        slot_q[c]   <= '0;
        seeded_q[c] <= 1'b0;
      end
    end else if (clear_all) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        count_q[c]  <= '0;
        slot_q[c]   <= '0;
        seeded_q[c] <= 1'b0;
      end
    end else if (clear_chan) begin
      count_q[in_ch]  <= '0;
      slot_q[in_ch]   <= '0;
      seeded_q[in_ch] <= 1'b0;
    end else if (state_q == ST_SUM) begin
      count_q[ch_q] <= new_count;
      slot_q[ch_q]  <= new_slot;
    end else if (state_q == ST_MUL_NEW && !cur_seeded) begin
      seeded_q[ch_q] <= 1'b1;
    end
  end

  // Per-channel sums and estimates
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SUM) begin
      sum_q[ch_q] <= new_sum;
    end
    if (state_q == ST_MUL_NEW && !cur_seeded) begin
      smooth_q[ch_q] <= s_seed;
    end else if (state_q == ST_EXP) begin
      smooth_q[ch_q] <= s_new;
    end
  end

  // History memory: read the oldest sample, write the new one
  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      hist_rd_q <= hist_mem[rd_addr];
    end
    if (state_q == ST_SUM) begin
      hist_mem[wr_addr] <= x_q;
    end
  end

  // Ports
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'h0, out_val_q, out_ch_q};
  assign m_axis_tuser  = out_pass_q;

  // Assertions
  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> state_q == ST_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_count_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SUM |-> cur_count <= win_eff)
    else $error("held count above the window");

  a_slot_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> {1'b0, cur_slot} < win_eff)
    else $error("oldest slot outside the window");

  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid && state_q == ST_IDLE)
    else $error("result not presented after load");

endmodule

>>> hw/rtl/msf_divider.sv
// ----------------------------------------------------------------------------
// msf_divider
// Serial restoring divider: signed running sum by an unsigned held count,
// one quotient bit a cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module msf_divider import msf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  div_req_t                req_i,
  output div_status_t             status_o,
  output logic signed [SUM_W-1:0] quotient_o
);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W-1:0]  rem_q;
  logic [SUM_W-1:0]  quo_q;
  logic [CNT_W-1:0]  dvs_q;
  logic              neg_q;

  logic [CNT_W:0]    rem_shift;
  logic              fits;
  logic [CNT_W:0]    rem_sub;
  logic [SUM_W-1:0]  magnitude;

  // One restoring step
  assign rem_shift = {rem_q, quo_q[SUM_W-1]};
  assign fits      = rem_shift >= {1'b0, dvs_q};
  assign rem_sub   = fits ? (rem_shift - {1'b0, dvs_q}) : rem_shift;
  assign magnitude = req_i.dividend[SUM_W-1] ? (~req_i.dividend + 1'b1) : req_i.dividend;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(SUM_W);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift the dividend out, the quotient in
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= magnitude;
      dvs_q <= req_i.divisor;
      neg_q <= req_i.dividend[SUM_W-1];
    end else if (busy_q) begin
      rem_q <= rem_sub[CNT_W-1:0];
      quo_q <= {quo_q[SUM_W-2:0], fits};
    end
  end

  assign quotient_o    = neg_q ? $signed(~quo_q + 1'b1) : $signed(quo_q);
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

>>> tb/multichannel_sensor_smoothing_filter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_sensor_smoothing_filter_test
// Self-checking bench for the per-channel smoothing filter. A class keeps its
// own copy of every channel's window, sum and Q16.16 estimate, predicts each
// result as items are accepted and compares the results in order. Register
// settings are swept between phases, both handshakes idle and stall at random,
// and the output is held off for a long stretch to back up the input.
// ----------------------------------------------------------------------------
module multichannel_sensor_smoothing_filter_test import msf_pkg::*; ();

  localparam int        DRAIN_CYCLES = 40;      // longest item plus margin
  localparam int        HOLD_CYCLES  = 300;     // long output hold-off
  localparam int        CYCLE_LIMIT  = 600000;
  localparam int        NUM_PHASES   = 11;
  localparam int        PHASE_ITEMS  = 70;
  localparam logic [1:0] CFG_UNUSED  = 2'd3;    // index with no register
  localparam logic      CONNECTED    = 1'b1;
  localparam logic      DISCONNECTED = 1'b0;

  typedef struct packed {
    logic [CH_W-1:0]               channel;
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          passed;
  } filter_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [23:0]         m_axis_tdata;
  logic [0:0]          m_axis_tuser;
  logic                cfg_we_i;
  logic [1:0]          cfg_index_i;
  logic [WEIGHT_W-1:0] cfg_data_i;

  int  cycle_count = 0;
  int  holds_requested = 0;
  int  holds_served = 0;
  int  cfg_writes = 0;
  bit  quiet = 1'b0;

  multichannel_sensor_smoothing_filter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // --------------------------------------------------------------------------
  // Smoothing predictor and result checker
  // --------------------------------------------------------------------------
  class smoothed_value_checker;
    logic                          mode;
    logic [CNT_W-1:0]              window;
    logic [WEIGHT_W-1:0]           weight;
    logic signed [SAMPLE_BITS-1:0] history [NUM_CHANNELS][MAX_WINDOW];
    longint                        window_sum [NUM_CHANNELS];
    int                            held [NUM_CHANNELS];
    int                            oldest [NUM_CHANNELS];
    longint                        estimate [NUM_CHANNELS];
    bit                            seeded [NUM_CHANNELS];
    filter_result_t                awaited_outputs [$];
    int                            errors;
    int                            items_seen;
    int                            results_seen;
    int                            passthroughs;

    function new();
      mode         = MODE_MOVING_AVG;
      window       = 6'd8;
      weight       = HALF_Q16;
      errors       = 0;
      items_seen   = 0;
      results_seen = 0;
      passthroughs = 0;
      foreach (history[c, s]) history[c][s] = '0;
      clear_all();
    endfunction

    function void clear_channel(int ch);
      window_sum[ch] = 0;
      held[ch]       = 0;
      oldest[ch]     = 0;
      estimate[ch]   = 0;
      seeded[ch]     = 1'b0;
    endfunction

    function void clear_all();
      for (int c = 0; c < NUM_CHANNELS; c++) clear_channel(c);
    endfunction

    // Mode and window writes drop all channel state; a weight write does not
    function void write_register(logic [1:0] idx, logic [WEIGHT_W-1:0] value);
      case (idx)
        CFG_FILTER_MODE: begin
          mode = value[0];
          clear_all();
        end
        CFG_WINDOW_LENGTH: begin
          window = value[CNT_W-1:0];
          clear_all();
        end
        CFG_SMOOTHING_WEIGHT: begin
          weight = value;
        end
        default: begin
        end
      endcase
    endfunction

    // Predict the result of one accepted item (every 4-bit channel exists)
    function void note_sample(logic kind, logic [CH_W-1:0] ch, logic conn,
                              logic signed [SAMPLE_BITS-1:0] x);
      filter_result_t res;
      longint         y;
      longint         a;
      longint         t;
      int             win;
      int             slot;
      items_seen++;
      if (kind == KIND_CLEAR_ALL) begin
        clear_all();
        return;
      end
      res.channel = ch;
      res.passed  = 1'b0;
      if (conn == DISCONNECTED) begin
        clear_channel(ch);
        res.value  = x;
        res.passed = 1'b1;
      end else if (mode == MODE_MOVING_AVG) begin
        // Clamp the window, then slide or fill the ring
        win = int'(window);
        if (win == 0) win = 1;
        if (win > MAX_WINDOW) win = MAX_WINDOW;
        slot = oldest[ch] % win;
        if (held[ch] >= win) begin
          window_sum[ch] -= history[ch][slot];
          history[ch][slot] = x;
          oldest[ch] = (slot + 1) % win;
          held[ch]   = win;
        end else begin
          history[ch][(slot + held[ch]) % win] = x;
          held[ch]++;
        end
        window_sum[ch] += x;
        // Signed division truncates toward zero
        y = window_sum[ch] / longint'(held[ch]);
        res.value = y[SAMPLE_BITS-1:0];
      end else begin
        // Seed on the first sample, then blend with round to nearest
        a = (weight > ONE_Q16) ? longint'(ONE_Q16) : longint'(weight);
        if (!seeded[ch]) begin
          estimate[ch] = longint'(x) * 65536;
          seeded[ch]   = 1'b1;
        end else begin
          t = a * (longint'(x) * 65536) + (65536 - a) * estimate[ch] + 32768;
          estimate[ch] = t >>> 16;
        end
        y = (estimate[ch] + 32768) >>> 16;
        res.value = y[SAMPLE_BITS-1:0];
      end
      awaited_outputs.insert(awaited_outputs.size(), res);
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_output(filter_result_t got);
      filter_result_t want;
      results_seen++;
      if (got.passed) passthroughs++;
      if (awaited_outputs.size() == 0) begin
        errors++;
        $display("%0t: unexpected result ch=%0d value=%0d passed=%0b", $time,
                 got.channel, got.value, got.passed);
        return;
      end
      want = awaited_outputs[0];
      awaited_outputs.delete(0);
      if (got !== want) begin
        errors++;
        $display("%0t: expected ch=%0d val=%0d pt=%0b, actual ch=%0d val=%0d pt=%0b",
                 $time, want.channel, want.value, want.passed,
                 got.channel, got.value, got.passed);
      end
    endfunction
  endclass

  smoothed_value_checker chk;

  // Sample both handshakes at the rising edge; retire results before new items
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      chk.check_output({m_axis_tdata[3:0], m_axis_tdata[19:4], m_axis_tuser[0]});
    end
    if (s_axis_tvalid && s_axis_tready) begin
      chk.note_sample(s_axis_tuser[0], s_axis_tdata[3:0], s_axis_tuser[1],
                      s_axis_tdata[19:4]);
    end
  end

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               chk.awaited_outputs.size());
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: long hold-offs on request, random stalls otherwise
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_requested != holds_served) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        holds_served++;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        m_axis_tready = 1'b0;
        stall = $urandom_range(1, 12);
        repeat (stall - 1) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Offer one item, maybe after a random gap, and hold it until accepted
  task automatic send_sample(logic kind, logic [CH_W-1:0] ch, logic conn,
                             logic signed [SAMPLE_BITS-1:0] x);
    int          gap;
    logic [31:0] junk;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap  = $urandom_range(1, 12);
      junk = $urandom;
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = junk[23:0];
      s_axis_tuser  = junk[31:30];
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {4'b0000, x, ch};
    s_axis_tuser  = {conn, kind};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Drop the input and wait for every result, optionally for the tail too
  task automatic idle_until_drained(bit with_tail);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (chk.awaited_outputs.size() != 0) @(posedge clk_i);
    if (with_tail) repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write one register; only called with the block idle
  task automatic write_cfg(logic [1:0] idx, logic [WEIGHT_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    chk.write_register(idx, value);
    cfg_writes++;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Some extremes and small values, mostly anywhere in range
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0:       pick_sample = 16'sh7FFF;
      1:       pick_sample = 16'sh8000;
      2:       pick_sample = {{13{r[3]}}, r[2:0]};
      default: pick_sample = r[15:0];
    endcase
  endfunction

  // Random item: mostly connected samples on a few channels
  task automatic send_random(int narrow);
    int              r;
    logic [31:0]     bits;
    logic [CH_W-1:0] ch;
    r    = $urandom_range(0, 99);
    bits = $urandom;
    if ($urandom_range(0, 3) == 0) ch = bits[3:0];
    else ch = CH_W'($urandom_range(0, narrow));
    if (r < 2) send_sample(KIND_CLEAR_ALL, bits[7:4], bits[8], bits[24:9]);
    else if (r < 8) send_sample(KIND_SAMPLE, ch, DISCONNECTED, pick_sample());
    else send_sample(KIND_SAMPLE, ch, CONNECTED, pick_sample());
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [31:0]   junk;
    logic          mode_sel;
    logic [5:0]    win_sel;
    logic [16:0]   weight_sel;
    int            narrow;
    chk = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_FILTER_MODE;
    cfg_data_i    = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: moving average over 8, fill and slide at full scale
    repeat (9) send_sample(KIND_SAMPLE, 4'd0, CONNECTED, 16'sh7FFF);
    repeat (2) send_sample(KIND_SAMPLE, 4'd1, CONNECTED, 16'sh8000);
    // Negative mean truncates toward zero
    send_sample(KIND_SAMPLE, 4'd2, CONNECTED, -16'sd1);
    send_sample(KIND_SAMPLE, 4'd2, CONNECTED, -16'sd2);
    // Disconnected samples pass through raw and clear the channel
    send_sample(KIND_SAMPLE, 4'd3, DISCONNECTED, 16'sh8000);
    send_sample(KIND_SAMPLE, 4'd0, DISCONNECTED, 16'sh7FFF);
    send_sample(KIND_SAMPLE, 4'd0, CONNECTED, 16'sd5);
    // Clear-all gives no result and empties every window
    send_sample(KIND_CLEAR_ALL, 4'd15, CONNECTED, 16'sh7FFF);
    send_sample(KIND_SAMPLE, 4'd1, CONNECTED, 16'sh8000);
    send_sample(KIND_SAMPLE, 4'd15, CONNECTED, 16'sd1);

    // Exponential smoothing at the reset weight: seed, blend, reseed
    idle_until_drained(1'b1);
    write_cfg(CFG_FILTER_MODE, {16'h0000, MODE_EXP_SMOOTH});
    send_sample(KIND_SAMPLE, 4'd4, CONNECTED, 16'sh7FFF);
    send_sample(KIND_SAMPLE, 4'd4, CONNECTED, 16'sh8000);
    send_sample(KIND_SAMPLE, 4'd4, CONNECTED, 16'sh8000);
    send_sample(KIND_SAMPLE, 4'd4, DISCONNECTED, 16'sd77);
    send_sample(KIND_SAMPLE, 4'd4, CONNECTED, 16'sh8000);

    // Random phases, one register setting each
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      idle_until_drained(1'b1);
      mode_sel   = MODE_MOVING_AVG;
      win_sel    = 6'd8;
      weight_sel = HALF_Q16;
      narrow     = 3;
      case (phase)
        0: begin
          win_sel = 6'd32;
          narrow  = 1;
        end
        1: win_sel = 6'd1;
        2: win_sel = 6'd0;
        3: win_sel = 6'd63;
        4: win_sel = 6'($urandom_range(2, 31));
        5: begin
          mode_sel   = MODE_EXP_SMOOTH;
          weight_sel = 17'd0;
        end
        6: begin
          mode_sel   = MODE_EXP_SMOOTH;
          weight_sel = ONE_Q16;
        end
        7: begin
          mode_sel   = MODE_EXP_SMOOTH;
          weight_sel = 17'h1FFFF;
        end
        8: begin
          mode_sel   = MODE_EXP_SMOOTH;
          weight_sel = 17'd1;
        end
        9: begin
          mode_sel   = MODE_EXP_SMOOTH;
          weight_sel = 17'($urandom_range(0, 65536));
        end
        default: quiet = 1'b1;
      endcase
      // Upper data bits of the narrow registers carry junk
      junk = $urandom;
      write_cfg(CFG_SMOOTHING_WEIGHT, weight_sel);
      write_cfg(CFG_FILTER_MODE, {junk[15:0], mode_sel});
      write_cfg(CFG_WINDOW_LENGTH, {junk[26:16], win_sel});

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Back up the output while the input keeps offering
        if (phase == 4 && n == 5) holds_requested++;
        // Pause the sender until all results are in
        if (phase == 6 && n == 35) idle_until_drained(1'b0);
        // New weight without clearing, plus a write to the spare index
        if (phase == 9 && n == 35) begin
          idle_until_drained(1'b1);
          junk = $urandom;
          write_cfg(CFG_SMOOTHING_WEIGHT, junk[16:0]);
          write_cfg(CFG_UNUSED, junk[31:15]);
        end
        send_random(narrow);
      end
    end

    idle_until_drained(1'b1);
    $display("summary: %0d items in, %0d results (%0d passed through), %0d register writes",
             chk.items_seen, chk.results_seen, chk.passthroughs, cfg_writes);
    $display("summary: both filter modes, window and weight extremes, %0d mismatches",
             chk.errors);
    if (chk.errors == 0 && chk.awaited_outputs.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
